>>> hdl/tlds_pkg.sv
package tlds_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 30;
    localparam int PROD_W    = 2 * DATA_W;
    localparam int DVD_W     = DATA_W + FRAC_BITS;
    localparam int ROOT_W    = DVD_W / 2;
    localparam int GEN_W     = 16;
    localparam int POP_W     = 24;
    localparam int RATE_W    = 30;
    localparam int CFG_W     = 30;
    localparam int CFG_IDX_W = 2;
    localparam int RF_AW     = 5;
    localparam int PC_W      = 6;
    localparam int IN_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_POP_SIZE    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_RECOMB_RATE = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_GENERATIONS = CFG_IDX_W'(2);

    localparam logic [POP_W-1:0]  POP_SIZE_RST    = POP_W'(1000);
    localparam logic [RATE_W-1:0] RECOMB_RATE_RST = '0;
    localparam logic [GEN_W-1:0]  GENERATIONS_RST = GEN_W'(1);
    localparam logic [GEN_W-1:0]  GEN_MAX         = '1;

    localparam logic signed [DATA_W-1:0] Q_ONE = DATA_W'(64'd1 << FRAC_BITS);
    localparam logic signed [DATA_W-1:0] S_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic signed [DATA_W-1:0] S_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [PROD_W-1:0] S_MAX_W = PROD_W'(S_MAX);
    localparam logic signed [PROD_W-1:0] S_MIN_W = PROD_W'(S_MIN);

    // register file slots; the last three read as constants
    typedef enum logic [RF_AW-1:0] {
        R_P0, R_P1, R_P2, R_P3, R_U0, R_U1, R_U2,
        R_M0, R_M1, R_M2, R_SD0, R_SD1, R_SD2,
        R_A, R_B, R_C, R_K20, R_K21, R_K30, R_K31, R_K32,
        R_T0, R_T1, R_T2, R_ONE, R_REC, R_ZERO
    } rf_idx_t;

    typedef enum logic [2:0] {
        OP_MUL, OP_ADD, OP_SUB, OP_NEG, OP_TAIL, OP_DIV, OP_SDV, OP_SQRT
    } uop_op_t;

    typedef struct packed {
        uop_op_t op;
        rf_idx_t dst;
        rf_idx_t sa;
        rf_idx_t sb;
        rf_idx_t sc;
    } uop_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_IN_WR, ST_FETCH_A, ST_FETCH_B, ST_FETCH_C, ST_CAP_C,
        ST_RUN, ST_WAIT, ST_WB, ST_FINISH, ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        logic                 capture;
        logic                 in_wr;
        logic [IN_IDX_W-1:0]  in_idx;
        rf_idx_t              raddr;
        logic                 cap_a;
        logic                 cap_b;
        logic                 cap_c;
        logic                 run;
        logic                 wb;
        uop_op_t              op;
        rf_idx_t              dst;
        logic                 finish;
    } dp_cmd_t;

    typedef struct packed {
        logic is_step;
        logic unit_busy;
    } dp_stat_t;

    typedef struct packed {
        logic                      command;
        logic signed [DATA_W-1:0]  init_freq_0;
        logic signed [DATA_W-1:0]  init_freq_1;
        logic signed [DATA_W-1:0]  init_freq_2;
        logic signed [DATA_W-1:0]  init_freq_3;
        logic signed [DATA_W-1:0]  uniform_0;
        logic signed [DATA_W-1:0]  uniform_1;
        logic signed [DATA_W-1:0]  uniform_2;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  freq_0;
        logic signed [DATA_W-1:0]  freq_1;
        logic signed [DATA_W-1:0]  freq_2;
        logic signed [DATA_W-1:0]  freq_3;
        logic [GEN_W-1:0]          generation;
        logic                      run_done;
        logic                      numeric_error;
    } out_item_t;

    localparam logic [PC_W-1:0] UC_LAST = PC_W'(56);

    function automatic logic signed [DATA_W-1:0] sat_q(input logic signed [PROD_W-1:0] x);
        logic signed [DATA_W-1:0] r;
        if (x > S_MAX_W) begin
            r = S_MAX;
        end else if (x < S_MIN_W) begin
            r = S_MIN;
        end else begin
            r = DATA_W'(x);
        end
        return r;
    endfunction

    // one generation: recombination, drift coefficients, drift update
    function automatic uop_t ucode(input logic [PC_W-1:0] pc);
        uop_t u;
        unique case (pc)
            6'd0:  u = '{OP_MUL,  R_T0,  R_P0,  R_P3,  R_ZERO};
            6'd1:  u = '{OP_MUL,  R_T1,  R_P1,  R_P2,  R_ZERO};
            6'd2:  u = '{OP_SUB,  R_T0,  R_T0,  R_T1,  R_ZERO};
            6'd3:  u = '{OP_MUL,  R_T0,  R_REC, R_T0,  R_ZERO};
            6'd4:  u = '{OP_SUB,  R_P0,  R_P0,  R_T0,  R_ZERO};
            6'd5:  u = '{OP_ADD,  R_P1,  R_P1,  R_T0,  R_ZERO};
            6'd6:  u = '{OP_ADD,  R_P2,  R_P2,  R_T0,  R_ZERO};
            6'd7:  u = '{OP_SUB,  R_P3,  R_P3,  R_T0,  R_ZERO};
            6'd8:  u = '{OP_SUB,  R_M0,  R_ONE, R_P0,  R_ZERO};
            6'd9:  u = '{OP_SUB,  R_M1,  R_ONE, R_P1,  R_ZERO};
            6'd10: u = '{OP_SUB,  R_M2,  R_ONE, R_P2,  R_ZERO};
            6'd11: u = '{OP_MUL,  R_T0,  R_P0,  R_M0,  R_ZERO};
            6'd12: u = '{OP_SDV,  R_T0,  R_T0,  R_ZERO, R_ZERO};
            6'd13: u = '{OP_SQRT, R_SD0, R_T0,  R_ZERO, R_ZERO};
            6'd14: u = '{OP_MUL,  R_T0,  R_P1,  R_M1,  R_ZERO};
            6'd15: u = '{OP_SDV,  R_T0,  R_T0,  R_ZERO, R_ZERO};
            6'd16: u = '{OP_SQRT, R_SD1, R_T0,  R_ZERO, R_ZERO};
            6'd17: u = '{OP_MUL,  R_T0,  R_P2,  R_M2,  R_ZERO};
            6'd18: u = '{OP_SDV,  R_T0,  R_T0,  R_ZERO, R_ZERO};
            6'd19: u = '{OP_SQRT, R_SD2, R_T0,  R_ZERO, R_ZERO};
            6'd20: u = '{OP_MUL,  R_T0,  R_P0,  R_P1,  R_ZERO};
            6'd21: u = '{OP_MUL,  R_T1,  R_M0,  R_M1,  R_ZERO};
            6'd22: u = '{OP_DIV,  R_A,   R_T0,  R_T1,  R_ZERO};
            6'd23: u = '{OP_SQRT, R_T0,  R_A,   R_ZERO, R_ZERO};
            6'd24: u = '{OP_NEG,  R_K20, R_T0,  R_ZERO, R_ZERO};
            6'd25: u = '{OP_SUB,  R_T0,  R_ONE, R_A,   R_ZERO};
            6'd26: u = '{OP_SQRT, R_K21, R_T0,  R_ZERO, R_ZERO};
            6'd27: u = '{OP_MUL,  R_T0,  R_P0,  R_P2,  R_ZERO};
            6'd28: u = '{OP_MUL,  R_T1,  R_M0,  R_M2,  R_ZERO};
            6'd29: u = '{OP_DIV,  R_B,   R_T0,  R_T1,  R_ZERO};
            6'd30: u = '{OP_MUL,  R_T0,  R_P1,  R_P2,  R_ZERO};
            6'd31: u = '{OP_MUL,  R_T1,  R_M1,  R_M2,  R_ZERO};
            6'd32: u = '{OP_DIV,  R_C,   R_T0,  R_T1,  R_ZERO};
            6'd33: u = '{OP_SQRT, R_T0,  R_B,   R_ZERO, R_ZERO};
            6'd34: u = '{OP_NEG,  R_K30, R_T0,  R_ZERO, R_ZERO};
            6'd35: u = '{OP_SQRT, R_T0,  R_C,   R_ZERO, R_ZERO};
            6'd36: u = '{OP_DIV,  R_T0,  R_T0,  R_M0,  R_ZERO};
            6'd37: u = '{OP_NEG,  R_K31, R_T0,  R_ZERO, R_ZERO};
            6'd38: u = '{OP_MUL,  R_T1,  R_M0,  R_M0,  R_ZERO};
            6'd39: u = '{OP_DIV,  R_T1,  R_C,   R_T1,  R_ZERO};
            6'd40: u = '{OP_SUB,  R_T0,  R_ONE, R_B,   R_ZERO};
            6'd41: u = '{OP_SUB,  R_T0,  R_T0,  R_T1,  R_ZERO};
            6'd42: u = '{OP_SQRT, R_K32, R_T0,  R_ZERO, R_ZERO};
            6'd43: u = '{OP_MUL,  R_T0,  R_SD0, R_U0,  R_ZERO};
            6'd44: u = '{OP_ADD,  R_P0,  R_P0,  R_T0,  R_ZERO};
            6'd45: u = '{OP_MUL,  R_T0,  R_K20, R_U0,  R_ZERO};
            6'd46: u = '{OP_MUL,  R_T1,  R_K21, R_U1,  R_ZERO};
            6'd47: u = '{OP_ADD,  R_T0,  R_T0,  R_T1,  R_ZERO};
            6'd48: u = '{OP_MUL,  R_T0,  R_SD1, R_T0,  R_ZERO};
            6'd49: u = '{OP_ADD,  R_P1,  R_P1,  R_T0,  R_ZERO};
            6'd50: u = '{OP_MUL,  R_T0,  R_K30, R_U0,  R_ZERO};
            6'd51: u = '{OP_MUL,  R_T1,  R_K31, R_U1,  R_ZERO};
            6'd52: u = '{OP_MUL,  R_T2,  R_K32, R_U2,  R_ZERO};
            6'd53: u = '{OP_ADD,  R_T0,  R_T0,  R_T1,  R_T2};
            6'd54: u = '{OP_MUL,  R_T0,  R_SD2, R_T0,  R_ZERO};
            6'd55: u = '{OP_ADD,  R_P2,  R_P2,  R_T0,  R_ZERO};
            6'd56: u = '{OP_TAIL, R_P3,  R_P0,  R_P1,  R_P2};
            default: u = '{OP_ADD, R_T2, R_ZERO, R_ZERO, R_ZERO};
        endcase
        return u;
    endfunction

endpackage

>>> hdl/tlds_div.sv
module tlds_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tlds_pkg::DVD_W-1:0]    dividend,
    input  logic [tlds_pkg::DATA_W-1:0]   divisor,
    output logic                          busy,
    output logic [tlds_pkg::DATA_W-1:0]   quotient,
    output logic                          overflow
);
    import tlds_pkg::*;

    localparam int CNT_W = $clog2(DVD_W);

    // restoring division, one quotient bit per cycle
    logic                 busy_reg, busy_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DVD_W-1:0]     dvd_reg, dvd_next;
    logic [DATA_W-1:0]    dsr_reg, dsr_next;
    logic [DATA_W-1:0]    rem_reg, rem_next;
    logic [DATA_W-1:0]    quo_reg, quo_next;
    logic                 ovf_reg, ovf_next;
    logic [DATA_W:0]      rem_sh;
    logic [DATA_W:0]      diff;
    logic                 ge;

    always_comb begin
        rem_sh = {rem_reg, dvd_reg[DVD_W-1]};
        diff   = rem_sh - {1'b0, dsr_reg};
        ge     = rem_sh >= {1'b0, dsr_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        ovf_next  = ovf_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = dividend;
            dsr_next  = divisor;
            rem_next  = '0;
            quo_next  = '0;
            ovf_next  = 1'b0;
        end else if (busy_reg) begin
            rem_next = ge ? diff[DATA_W-1:0] : rem_sh[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], ge};
            ovf_next = ovf_reg | quo_reg[DATA_W-1];
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DVD_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        ovf_reg <= ovf_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
    assign overflow = ovf_reg;

endmodule

>>> hdl/tlds_sqrt.sv
module tlds_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [tlds_pkg::DVD_W-1:0]    radicand,
    output logic                          busy,
    output logic [tlds_pkg::ROOT_W-1:0]   root
);
    import tlds_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);
    localparam int REM_W = ROOT_W + 3;

    // digit recurrence, two radicand bits per cycle
    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [DVD_W-1:0]   rad_reg, rad_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [REM_W-1:0]   rem_sh;
    logic [REM_W-1:0]   trial;
    logic               ge;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[DVD_W-1 -: 2]};
        trial  = {1'b0, root_reg, 2'b01};
        ge     = rem_sh >= trial;
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rad_next  = rad_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rad_next  = radicand;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_reg[ROOT_W-2:0], ge};
            rad_next  = {rad_reg[DVD_W-3:0], 2'b00};
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1)) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rad_reg  <= rad_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

>>> hdl/tlds_dpath.sv
module tlds_dpath (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  tlds_pkg::in_item_t            s_data,
    input  logic [tlds_pkg::POP_W-1:0]    pop_size,
    input  logic [tlds_pkg::RATE_W-1:0]   recomb_rate,
    input  logic [tlds_pkg::GEN_W-1:0]    generations,
    input  tlds_pkg::dp_cmd_t             cmd,
    output tlds_pkg::dp_stat_t            stat,
    output tlds_pkg::out_item_t           m_data
);
    import tlds_pkg::*;

    localparam int SUM_W = DATA_W + 2;

    in_item_t                  in_reg;
    logic [DATA_W-1:0]         rf_mem [0:(2**RF_AW)-1];
    logic signed [DATA_W-1:0]  rdata_reg;
    rf_idx_t                   ridx_reg;
    logic signed [DATA_W-1:0]  opa_reg, opb_reg, opc_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [DATA_W-1:0]  freq_reg [0:3];
    logic [GEN_W-1:0]          gen_reg, gen_next;
    logic                      err_reg, err_next;

    logic signed [DATA_W-1:0]  operand;
    logic                      we;
    logic [RF_AW-1:0]          waddr;
    logic signed [DATA_W-1:0]  wdata;
    logic signed [DATA_W-1:0]  in_val;
    logic signed [DATA_W-1:0]  wb_val;
    logic                      wb_err;

    logic                      div_start, sqrt_start, div_busy, sqrt_busy, div_ovf;
    logic [DVD_W-1:0]          div_dvd;
    logic [DATA_W-1:0]         div_dsr, div_q, abs_a, abs_b;
    logic [ROOT_W-1:0]         sq_root;

    logic signed [PROD_W-1:0]  prod_sh;
    logic signed [SUM_W-1:0]   sum3, diff2, neg1, tail;
    logic                      q_neg, q_bad;

    // constant slots are decoded after the registered read; frequency slots
    // come from the reset mirror so a step right after reset sees zeros
    always_comb begin
        unique case (ridx_reg) inside
            R_P0, R_P1, R_P2, R_P3: operand = freq_reg[ridx_reg[1:0]];
            R_ONE:   operand = Q_ONE;
            R_REC:   operand = DATA_W'(recomb_rate);
            R_ZERO:  operand = '0;
            default: operand = rdata_reg;
        endcase
    end

    always_comb begin
        if (in_reg.command) begin
            case (cmd.in_idx)
                2'd0:    in_val = in_reg.uniform_0;
                2'd1:    in_val = in_reg.uniform_1;
                default: in_val = in_reg.uniform_2;
            endcase
        end else begin
            case (cmd.in_idx)
                2'd0:    in_val = in_reg.init_freq_0;
                2'd1:    in_val = in_reg.init_freq_1;
                2'd2:    in_val = in_reg.init_freq_2;
                default: in_val = in_reg.init_freq_3;
            endcase
        end
    end

    assign we    = cmd.in_wr | cmd.wb;
    assign waddr = cmd.in_wr
                 ? ((in_reg.command ? RF_AW'(R_U0) : RF_AW'(R_P0)) + RF_AW'(cmd.in_idx))
                 : RF_AW'(cmd.dst);
    assign wdata = cmd.in_wr ? in_val : wb_val;

    // divider and root operands
    assign abs_a      = opa_reg[DATA_W-1] ? (~opa_reg + 1'b1) : opa_reg;
    assign abs_b      = opb_reg[DATA_W-1] ? (~opb_reg + 1'b1) : opb_reg;
    assign div_start  = cmd.run && (cmd.op == OP_DIV || cmd.op == OP_SDV);
    assign sqrt_start = cmd.run && (cmd.op == OP_SQRT);
    assign div_dvd    = (cmd.op == OP_SDV) ? DVD_W'(unsigned'(opa_reg))
                                           : {abs_a, {FRAC_BITS{1'b0}}};
    assign div_dsr    = (cmd.op == OP_SDV) ? DATA_W'(pop_size) : abs_b;

    tlds_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dsr),
        .busy     (div_busy),
        .quotient (div_q),
        .overflow (div_ovf)
    );

    tlds_sqrt u_sqrt (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (sqrt_start),
        .radicand ({opa_reg, {FRAC_BITS{1'b0}}}),
        .busy     (sqrt_busy),
        .root     (sq_root)
    );

    // write-back value and error flag
    always_comb begin
        prod_sh = prod_reg >>> FRAC_BITS;
        sum3    = SUM_W'(opa_reg) + SUM_W'(opb_reg) + SUM_W'(opc_reg);
        diff2   = SUM_W'(opa_reg) - SUM_W'(opb_reg);
        neg1    = -SUM_W'(opa_reg);
        tail    = SUM_W'(Q_ONE) - SUM_W'(opa_reg) - SUM_W'(opb_reg) - SUM_W'(opc_reg);
        q_neg   = opa_reg[DATA_W-1] ^ opb_reg[DATA_W-1];
        q_bad   = div_ovf || (q_neg ? (div_q > unsigned'(S_MIN)) : div_q[DATA_W-1]);
        wb_err  = 1'b0;
        wb_val  = '0;
        unique case (cmd.op)
            OP_MUL:  wb_val = sat_q(prod_sh);
            OP_ADD:  wb_val = sat_q(PROD_W'(sum3));
            OP_SUB:  wb_val = sat_q(PROD_W'(diff2));
            OP_NEG:  wb_val = sat_q(PROD_W'(neg1));
            OP_TAIL: wb_val = sat_q(PROD_W'(tail));
            OP_DIV: begin
                if (opb_reg == '0) begin
                    wb_err = 1'b1;
                    wb_val = opa_reg[DATA_W-1] ? S_MIN : S_MAX;
                end else if (q_bad) begin
                    wb_err = 1'b1;
                    wb_val = q_neg ? S_MIN : S_MAX;
                end else begin
                    wb_val = q_neg ? signed'(~div_q + 1'b1) : signed'(div_q);
                end
            end
            OP_SDV: begin
                if (opa_reg[DATA_W-1]) begin
                    wb_err = 1'b1;
                end else if (pop_size == '0) begin
                    wb_err = 1'b1;
                    wb_val = S_MAX;
                end else begin
                    wb_val = signed'(div_q);
                end
            end
            OP_SQRT: begin
                if (opa_reg[DATA_W-1]) begin
                    wb_err = 1'b1;
                end else begin
                    wb_val = signed'(DATA_W'(sq_root));
                end
            end
            default: wb_val = '0;
        endcase
    end

    always_comb begin
        gen_next = gen_reg;
        err_next = err_reg;
        if (cmd.capture) begin
            err_next = 1'b0;
        end else if (cmd.wb && wb_err) begin
            err_next = 1'b1;
        end
        if (cmd.finish) begin
            if (!in_reg.command) begin
                gen_next = '0;
            end else if (gen_reg != GEN_MAX) begin
                gen_next = gen_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gen_reg <= '0;
            err_reg <= 1'b0;
        end else begin
            gen_reg <= gen_next;
            err_reg <= err_next;
        end
    end

    // register file: one write, one registered read
    always_ff @(posedge aclk) begin
        if (we) begin
            rf_mem[waddr] <= wdata;
        end
        rdata_reg <= rf_mem[cmd.raddr];
    end

    // frequency slots are mirrored for the result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 4; i++) begin
                freq_reg[i] <= '0;
            end
        end else if (we && waddr < RF_AW'(R_U0)) begin
            freq_reg[waddr[1:0]] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        ridx_reg <= cmd.raddr;
        if (cmd.capture) in_reg  <= s_data;
        if (cmd.cap_a)   opa_reg <= operand;
        if (cmd.cap_b)   opb_reg <= operand;
        if (cmd.cap_c)   opc_reg <= operand;
        if (cmd.run && cmd.op == OP_MUL) begin
            prod_reg <= opa_reg * opb_reg;
        end
    end

    assign stat.is_step   = in_reg.command;
    assign stat.unit_busy = div_busy | sqrt_busy;

    assign m_data.freq_0        = freq_reg[0];
    assign m_data.freq_1        = freq_reg[1];
    assign m_data.freq_2        = freq_reg[2];
    assign m_data.freq_3        = freq_reg[3];
    assign m_data.generation    = gen_reg;
    assign m_data.run_done      = (gen_reg == generations);
    assign m_data.numeric_error = err_reg;

endmodule

>>> hdl/tlds_ctrl.sv
module tlds_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    output logic                  m_valid,
    input  logic                  m_ready,
    input  tlds_pkg::dp_stat_t    stat,
    output tlds_pkg::dp_cmd_t     cmd
);
    import tlds_pkg::*;

    ctrl_state_t           state_reg, state_next;
    logic [PC_W-1:0]       pc_reg, pc_next;
    logic [IN_IDX_W-1:0]   idx_reg, idx_next;
    uop_t                  uop;
    logic                  in_last;

    assign uop     = ucode(pc_reg);
    assign in_last = (idx_reg == (stat.is_step ? IN_IDX_W'(2) : IN_IDX_W'(3)));

    always_comb begin
        state_next = state_reg;
        pc_next    = pc_reg;
        idx_next   = idx_reg;
        s_ready    = 1'b0;
        m_valid    = 1'b0;
        cmd        = '0;
        cmd.op     = uop.op;
        cmd.dst    = uop.dst;
        cmd.raddr  = R_ZERO;
        cmd.in_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    idx_next    = '0;
                    state_next  = ST_IN_WR;
                end
            end
            ST_IN_WR: begin
                cmd.in_wr = 1'b1;
                if (in_last) begin
                    pc_next    = '0;
                    state_next = stat.is_step ? ST_FETCH_A : ST_FINISH;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_FETCH_A: begin
                cmd.raddr  = uop.sa;
                state_next = ST_FETCH_B;
            end
            ST_FETCH_B: begin
                cmd.cap_a  = 1'b1;
                cmd.raddr  = uop.sb;
                state_next = ST_FETCH_C;
            end
            ST_FETCH_C: begin
                cmd.cap_b  = 1'b1;
                cmd.raddr  = uop.sc;
                state_next = ST_CAP_C;
            end
            ST_CAP_C: begin
                cmd.cap_c  = 1'b1;
                state_next = ST_RUN;
            end
            ST_RUN: begin
                cmd.run = 1'b1;
                if (uop.op == OP_DIV || uop.op == OP_SDV || uop.op == OP_SQRT) begin
                    state_next = ST_WAIT;
                end else begin
                    state_next = ST_WB;
                end
            end
            ST_WAIT: begin
                if (!stat.unit_busy) begin
                    state_next = ST_WB;
                end
            end
            ST_WB: begin
                cmd.wb = 1'b1;
                if (pc_reg == UC_LAST) begin
                    state_next = ST_FINISH;
                end else begin
                    pc_next    = pc_reg + 1'b1;
                    state_next = ST_FETCH_A;
                end
            end
            ST_FINISH: begin
                cmd.finish = 1'b1;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                m_valid = 1'b1;
                if (m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            pc_reg    <= '0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            idx_reg   <= idx_next;
        end
    end

endmodule

>>> hdl/two_locus_drift_recombination_step_unit.sv
// Channel   Ports                          Moves
// input     s_valid, s_ready, s_data       one command: load or generation step
// result    m_valid, m_ready, m_data       frequencies, generation, run_done, error
// config    cfg_we, cfg_index, cfg_wdata   pop_size, recomb_rate, generations
//
// One item at a time. A load runs from input transfer to result transfer through
// 4 input writes, finish and output. A step runs 3 input writes, then a 57-entry
// micro-sequence of fetch, run and write-back per micro-op, with a wait for the
// unit on each of 8 divider uses and on each of 8 root uses.
// Reset (aresetn low, synchronous) clears the sequencer, counter, error flag,
// stored frequencies and loads register defaults. A stalled result holds the
// block; the next input transfer is taken after the result transfer.
module two_locus_drift_recombination_step_unit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  tlds_pkg::in_item_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output tlds_pkg::out_item_t               m_data,
    input  logic                              cfg_we,
    input  logic [tlds_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [tlds_pkg::CFG_W-1:0]        cfg_wdata
);
    import tlds_pkg::*;

    logic [POP_W-1:0]   pop_size_reg;
    logic [RATE_W-1:0]  recomb_rate_reg;
    logic [GEN_W-1:0]   generations_reg;
    dp_cmd_t            cmd;
    dp_stat_t           stat;

    // config registers; writes to an unused index are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pop_size_reg    <= POP_SIZE_RST;
            recomb_rate_reg <= RECOMB_RATE_RST;
            generations_reg <= GENERATIONS_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_POP_SIZE:    pop_size_reg    <= cfg_wdata[POP_W-1:0];
                CFG_RECOMB_RATE: recomb_rate_reg <= cfg_wdata[RATE_W-1:0];
                CFG_GENERATIONS: generations_reg <= cfg_wdata[GEN_W-1:0];
                default: ;
            endcase
        end
    end

    // sequencer: input writes, micro-op fetch/run/write-back, result
    tlds_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // register file, multiplier, divider, root unit, counters
    tlds_dpath u_dpath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_data      (s_data),
        .pop_size    (pop_size_reg),
        .recomb_rate (recomb_rate_reg),
        .generations (generations_reg),
        .cmd         (cmd),
        .stat        (stat),
        .m_data      (m_data)
    );

    // input and result sides are never open together
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_ready && m_valid))
        else $error("input open while a result is pending");

    // an accepted item closes the input
    a_close_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input still open after transfer");

    // run_done tracks the generation count
    a_run_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.run_done == (m_data.generation == generations_reg)))
        else $error("run_done inconsistent with generation");

endmodule

>>> bench/tb_two_locus_drift_recombination_step_unit.sv
module tb_two_locus_drift_recombination_step_unit;
    import tlds_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // command codes of the input item
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam longint SAT_HI = 64'sd2147483647;
    localparam longint SAT_LO = -64'sd2147483648;
    localparam longint ONE_Q  = 64'sd1 << FRAC_BITS;
    // uniform samples are meant to lie within plus/minus sqrt(3)
    localparam int     U_SPAN = 1859775393;
    localparam int     HOLD_CYCLES = 4000;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_valid;
    logic                   s_ready;
    in_item_t               s_data;
    logic                   m_valid;
    logic                   m_ready;
    out_item_t              m_data;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]       cfg_wdata;

    two_locus_drift_recombination_step_unit dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor state and its copy of the registers
    longint      hap_q[4];
    int unsigned gen_cnt;
    int unsigned pop_reg;
    int unsigned rate_reg;
    int unsigned gens_reg;
    bit          step_err;

    out_item_t   freq_exp_q[$];
    int          n_fail;
    int          n_loads;
    int          n_steps;
    int          n_err_results;
    int          n_done_results;
    int          send_idle_pct;
    int          recv_idle_pct;
    int          recv_hold;
    bit          hold_req;
    bit          hold_ack;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("FAILURE");
        $finish;
    end

    // ---------------- fixed-point predictor ----------------

    function automatic longint sat32(longint x);
        if (x > SAT_HI) return SAT_HI;
        if (x < SAT_LO) return SAT_LO;
        return x;
    endfunction

    // arithmetic shift of a signed product rounds toward minus infinity
    function automatic longint fx_mul(longint a, longint b);
        return sat32((a * b) >>> FRAC_BITS);
    endfunction

    function automatic longint fx_div(longint a, longint b);
        bit                neg;
        longint unsigned   ua, ub, lim, q, r;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? -a : a;
        ub  = (b < 0) ? -b : b;
        lim = neg ? 64'd2147483648 : 64'd2147483647;
        if (ub == 0) begin
            step_err = 1'b1;
            return (a >= 0) ? SAT_HI : SAT_LO;
        end
        q = ua / ub;
        r = ua % ub;
        if (q > lim) begin
            step_err = 1'b1;
            return neg ? SAT_LO : SAT_HI;
        end
        for (int i = 0; i < FRAC_BITS; i++) begin
            r = r << 1;
            q = q << 1;
            if (r >= ub) begin
                r = r - ub;
                q = q | 64'd1;
            end
            if (q > lim) begin
                step_err = 1'b1;
                return neg ? SAT_LO : SAT_HI;
            end
        end
        return neg ? -longint'(q) : longint'(q);
    endfunction

    function automatic longint fx_sqrt(longint v);
        longint unsigned uv, big, res, c;
        bit              huge;
        if (v < 0) begin
            step_err = 1'b1;
            return 0;
        end
        uv   = v;
        huge = (uv >> (64 - FRAC_BITS)) != 0;
        big  = huge ? 64'd0 : (uv << FRAC_BITS);
        res  = 0;
        for (int b = 31; b >= 0; b--) begin
            c = res | (64'd1 << b);
            if (huge || c * c <= big) res = c;
        end
        return (res > 64'd2147483647) ? SAT_HI : longint'(res);
    endfunction

    function automatic longint drift_sd(longint p);
        longint x;
        x = fx_mul(p, sat32(ONE_Q - p));
        if (x < 0) begin
            step_err = 1'b1;
            x = 0;
        end else if (pop_reg == 0) begin
            step_err = 1'b1;
            x = SAT_HI;
        end else begin
            x = x / longint'(pop_reg);
        end
        return fx_sqrt(x);
    endfunction

    // one generation: recombination, then correlated drift
    function automatic void advance_generation(longint u0, longint u1, longint u2);
        longint d, rd, sd0, sd1, sd2, m0, m1, m2, a, b, c;
        longint k20, k21, k30, k31, k32, e0, e1, e2;
        d  = sat32(fx_mul(hap_q[0], hap_q[3]) - fx_mul(hap_q[1], hap_q[2]));
        rd = fx_mul(longint'(rate_reg), d);
        hap_q[0] = sat32(hap_q[0] - rd);
        hap_q[1] = sat32(hap_q[1] + rd);
        hap_q[2] = sat32(hap_q[2] + rd);
        hap_q[3] = sat32(hap_q[3] - rd);
        sd0 = drift_sd(hap_q[0]);
        sd1 = drift_sd(hap_q[1]);
        sd2 = drift_sd(hap_q[2]);
        m0  = sat32(ONE_Q - hap_q[0]);
        m1  = sat32(ONE_Q - hap_q[1]);
        m2  = sat32(ONE_Q - hap_q[2]);
        a   = fx_div(fx_mul(hap_q[0], hap_q[1]), fx_mul(m0, m1));
        k20 = -fx_sqrt(a);
        k21 = fx_sqrt(sat32(ONE_Q - a));
        b   = fx_div(fx_mul(hap_q[0], hap_q[2]), fx_mul(m0, m2));
        c   = fx_div(fx_mul(hap_q[1], hap_q[2]), fx_mul(m1, m2));
        k30 = -fx_sqrt(b);
        k31 = sat32(-fx_div(fx_sqrt(c), m0));
        k32 = fx_sqrt(sat32(sat32(ONE_Q - b) - fx_div(c, fx_mul(m0, m0))));
        e0  = fx_mul(sd0, u0);
        e1  = fx_mul(sd1, sat32(fx_mul(k20, u0) + fx_mul(k21, u1)));
        e2  = fx_mul(sd2, sat32(fx_mul(k30, u0) + fx_mul(k31, u1) + fx_mul(k32, u2)));
        hap_q[0] = sat32(hap_q[0] + e0);
        hap_q[1] = sat32(hap_q[1] + e1);
        hap_q[2] = sat32(hap_q[2] + e2);
        hap_q[3] = sat32(ONE_Q - (hap_q[0] + hap_q[1] + hap_q[2]));
        if (gen_cnt < 32'hFFFF) gen_cnt++;
    endfunction

    function automatic out_item_t predict_freqs(in_item_t it);
        out_item_t r;
        step_err = 1'b0;
        if (it.command == CMD_LOAD) begin
            hap_q[0] = it.init_freq_0;
            hap_q[1] = it.init_freq_1;
            hap_q[2] = it.init_freq_2;
            hap_q[3] = it.init_freq_3;
            gen_cnt  = 0;
        end else begin
            advance_generation(it.uniform_0, it.uniform_1, it.uniform_2);
        end
        r.freq_0        = hap_q[0][31:0];
        r.freq_1        = hap_q[1][31:0];
        r.freq_2        = hap_q[2][31:0];
        r.freq_3        = hap_q[3][31:0];
        r.generation    = gen_cnt[15:0];
        r.run_done      = (gen_cnt == gens_reg);
        r.numeric_error = step_err;
        return r;
    endfunction

    // ---------------- monitors ----------------

    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            freq_exp_q.push_back(predict_freqs(s_data));
            if (s_data.command == CMD_LOAD) n_loads++;
            else n_steps++;
        end
    end

    always @(posedge aclk) begin
        out_item_t e;
        if (aresetn && m_valid && m_ready) begin
            if (freq_exp_q.size() == 0) begin
                $error("result transfer with nothing expected");
                n_fail++;
            end else begin
                e = freq_exp_q.pop_front();
                if (m_data.freq_0 !== e.freq_0) begin
                    $error("freq_0 exp %h got %h", e.freq_0, m_data.freq_0); n_fail++;
                end
                if (m_data.freq_1 !== e.freq_1) begin
                    $error("freq_1 exp %h got %h", e.freq_1, m_data.freq_1); n_fail++;
                end
                if (m_data.freq_2 !== e.freq_2) begin
                    $error("freq_2 exp %h got %h", e.freq_2, m_data.freq_2); n_fail++;
                end
                if (m_data.freq_3 !== e.freq_3) begin
                    $error("freq_3 exp %h got %h", e.freq_3, m_data.freq_3); n_fail++;
                end
                if (m_data.generation !== e.generation) begin
                    $error("generation exp %0d got %0d", e.generation, m_data.generation);
                    n_fail++;
                end
                if (m_data.run_done !== e.run_done) begin
                    $error("run_done exp %b got %b", e.run_done, m_data.run_done); n_fail++;
                end
                if (m_data.numeric_error !== e.numeric_error) begin
                    $error("numeric_error exp %b got %b", e.numeric_error,
                           m_data.numeric_error);
                    n_fail++;
                end
                if (e.numeric_error) n_err_results++;
                if (e.run_done) n_done_results++;
            end
        end
    end

    // receiver: random stalls, or a long hold-off when requested
    always @(posedge aclk) begin
        if (hold_req != hold_ack) begin
            hold_ack  <= hold_req;
            recv_hold <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else if (recv_hold > 0) begin
            m_ready   <= 1'b0;
            recv_hold <= recv_hold - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // ---------------- drivers ----------------

    // valid stays up between back-to-back transfers; it only drops on a gap
    task automatic send_item(in_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (freq_exp_q.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    // only called with nothing in flight
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= CFG_W'(val);
        @(posedge aclk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_POP_SIZE:    pop_reg  = val & 32'hFFFFFF;
            CFG_RECOMB_RATE: rate_reg = val & 32'h3FFFFFFF;
            CFG_GENERATIONS: gens_reg = val & 32'hFFFF;
            default: ;
        endcase
    endtask

    task automatic set_regs(int unsigned pop, int unsigned rate, int unsigned gens);
        wait_drained();
        write_reg(CFG_POP_SIZE, pop);
        write_reg(CFG_RECOMB_RATE, rate);
        write_reg(CFG_GENERATIONS, gens);
    endtask

    function automatic in_item_t mk_load(int f0, int f1, int f2, int f3);
        in_item_t it;
        it             = in_item_t'({$urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom});
        it.command     = CMD_LOAD;
        it.init_freq_0 = f0;
        it.init_freq_1 = f1;
        it.init_freq_2 = f2;
        it.init_freq_3 = f3;
        return it;
    endfunction

    function automatic in_item_t mk_step(int u0, int u1, int u2);
        in_item_t it;
        it           = in_item_t'({$urandom, $urandom, $urandom, $urandom,
                                   $urandom, $urandom, $urandom, $urandom});
        it.command   = CMD_STEP;
        it.uniform_0 = u0;
        it.uniform_1 = u1;
        it.uniform_2 = u2;
        return it;
    endfunction

    function automatic int rand_u();
        return int'($urandom_range(2 * U_SPAN)) - U_SPAN;
    endfunction

    // plausible haplotype set: three small parts, the fourth fills up to one
    function automatic in_item_t rand_load();
        int f0, f1, f2;
        f0 = $urandom_range(1 << 28);
        f1 = $urandom_range(1 << 28);
        f2 = $urandom_range(1 << 28);
        return mk_load(f0, f1, f2, int'(ONE_Q) - f0 - f1 - f2);
    endfunction

    // ---------------- tests ----------------

    task automatic test_load_extremes();
        send_item(mk_load(int'(SAT_LO), int'(SAT_LO), int'(SAT_LO), int'(SAT_LO)));
        send_item(mk_load(int'(SAT_HI), int'(SAT_HI), int'(SAT_HI), int'(SAT_HI)));
        send_item(mk_load(0, 0, 0, 0));
        send_item(mk_load(int'(SAT_HI), int'(SAT_LO), -1, 1));
    endtask

    task automatic test_step_cases();
        int q4;
        q4 = int'(ONE_Q) / 4;
        // step with zero samples, then from a balanced set with extreme samples
        send_item(mk_step(0, 0, 0));
        send_item(mk_load(q4, q4, q4, q4));
        send_item(mk_step(int'(SAT_HI), int'(SAT_HI), int'(SAT_HI)));
        send_item(mk_load(q4, q4, q4, q4));
        send_item(mk_step(int'(SAT_LO), int'(SAT_LO), int'(SAT_LO)));
        send_item(mk_step(U_SPAN, -U_SPAN, U_SPAN));
        // fixed allele: 1 - p0 is zero, so divisions hit a zero divisor
        send_item(mk_load(int'(ONE_Q), 0, 0, 0));
        send_item(mk_step(rand_u(), rand_u(), rand_u()));
        // negative frequency: negative radicand
        send_item(mk_load(-q4, q4, q4, int'(ONE_Q)));
        send_item(mk_step(rand_u(), rand_u(), rand_u()));
        // frequencies above one and saturating products
        send_item(mk_load(int'(SAT_HI), int'(SAT_HI), q4, int'(SAT_LO)));
        send_item(mk_step(rand_u(), rand_u(), rand_u()));
        send_item(mk_step(rand_u(), rand_u(), rand_u()));
    endtask

    // mostly a load followed by a run of steps; a few raw items as noise
    task automatic test_random_runs(int n_items);
        int sent;
        int run_len;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(99) < 12) begin
                send_item(in_item_t'({$urandom, $urandom, $urandom, $urandom,
                                      $urandom, $urandom, $urandom, $urandom}));
                sent++;
            end else begin
                send_item(rand_load());
                sent++;
                run_len = $urandom_range(1, 4);
                for (int i = 0; i < run_len && sent < n_items; i++) begin
                    if ($urandom_range(9) == 0)
                        send_item(mk_step($urandom, $urandom, $urandom));
                    else
                        send_item(mk_step(rand_u(), rand_u(), rand_u()));
                    sent++;
                end
            end
        end
    endtask

    task automatic test_random_config_phase(int n_items);
        int unsigned pop, rate, gens;
        case ($urandom_range(3))
            0: pop = 1;
            1: pop = 24'hFFFFFF;
            2: pop = 0;
            default: pop = $urandom_range(1, 24'hFFFFFF);
        endcase
        case ($urandom_range(3))
            0: rate = 0;
            1: rate = 32'h2000_0000;
            2: rate = 32'h3FFF_FFFF;
            default: rate = $urandom_range(0, 32'h2000_0000);
        endcase
        case ($urandom_range(3))
            0: gens = 0;
            1: gens = 16'hFFFF;
            default: gens = $urandom_range(1, 4);
        endcase
        set_regs(pop, rate, gens);
        test_random_runs(n_items);
    endtask

    // receiver holds off long while the sender keeps offering items
    task automatic test_backpressure();
        hold_req = ~hold_req;
        for (int i = 0; i < 4; i++) send_item(i % 2 ? mk_step(rand_u(), rand_u(), rand_u())
                                                     : rand_load());
    endtask

    initial begin
        hap_q          = '{default: 0};
        gen_cnt        = 0;
        pop_reg        = POP_SIZE_RST;
        rate_reg       = RECOMB_RATE_RST;
        gens_reg       = GENERATIONS_RST;
        n_fail         = 0;
        n_loads        = 0;
        n_steps        = 0;
        n_err_results  = 0;
        n_done_results = 0;
        send_idle_pct  = 15;
        recv_idle_pct  = 69;
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_data    <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_wdata <= '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset register values first
        test_load_extremes();
        test_step_cases();
        set_regs(1, 32'h2000_0000, 2);
        test_step_cases();

        send_idle_pct = 15;
        recv_idle_pct = 69;
        for (int k = 0; k < 4; k++) test_random_config_phase(50);
        test_backpressure();

        send_idle_pct = 69;
        recv_idle_pct = 15;
        for (int k = 0; k < 4; k++) test_random_config_phase(50);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_regs(1000, $urandom_range(0, 32'h2000_0000), 3);
        test_random_runs(100);
        for (int k = 0; k < 2; k++) test_random_config_phase(40);

        wait_drained();
        $display("covered %0d loads and %0d generation steps over several register settings",
                 n_loads, n_steps);
        $display("results flagging a numeric error: %0d, with run_done set: %0d",
                 n_err_results, n_done_results);
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

>>> filelist.f
hdl/tlds_pkg.sv
hdl/tlds_div.sv
hdl/tlds_sqrt.sv
hdl/tlds_dpath.sv
hdl/tlds_ctrl.sv
hdl/two_locus_drift_recombination_step_unit.sv
bench/tb_two_locus_drift_recombination_step_unit.sv
